/* src/mscc_pkg.sv */
package mscc_pkg;

    localparam int MAX_LEVELS = 8;

    localparam logic [1:0] CFG_THRESHOLD     = 2'd0;
    localparam logic [1:0] CFG_MULTI_MODE    = 2'd1;
    localparam logic [1:0] CFG_CELLS_PER_ROW = 2'd2;

    localparam logic [2:0] GLYPH_BLANK     = 3'd0;
    localparam logic [2:0] GLYPH_SLASH     = 3'd1;
    localparam logic [2:0] GLYPH_BACKSLASH = 3'd2;
    localparam logic [2:0] GLYPH_DASH      = 3'd3;
    localparam logic [2:0] GLYPH_BAR       = 3'd4;
    localparam logic [2:0] GLYPH_CROSS     = 3'd5;
    localparam logic [2:0] GLYPH_DOT_FILL  = 3'd6;
    localparam logic [2:0] GLYPH_FAINT     = 3'd7;

    localparam logic [2:0] STYLE_NONE      = 3'd0;
    localparam logic [2:0] STYLE_CONTOUR   = 3'd1;
    localparam logic [2:0] STYLE_INSIDE    = 3'd2;
    localparam logic [2:0] STYLE_LEVEL0    = 3'd3;
    localparam logic [2:0] STYLE_LEVEL_TOP = 3'd7;

    localparam logic [3:0] CASE_EMPTY = 4'd0;
    localparam logic [3:0] CASE_FULL  = 4'd15;

    typedef struct packed {
        logic [14:0] threshold;
        logic        multi_mode;
        logic [7:0]  cells_per_row;
    } t_cfg;

    typedef struct packed {
        logic [7:0]                  col;
        logic [7:0]                  row;
        logic [3:0]                  base_case;
        logic [MAX_LEVELS-1:0][3:0]  lvl_case;
    } t_cell;

    function automatic logic [16:0] level_factor(input logic [2:0] lv);
        logic [16:0] f;
        case (lv)
            3'd0:    f = 17'd19661;
            3'd1:    f = 17'd29491;
            3'd2:    f = 17'd39322;
            3'd3:    f = 17'd49152;
            3'd4:    f = 17'd58982;
            3'd5:    f = 17'd68813;
            3'd6:    f = 17'd78643;
            default: f = 17'd88474;
        endcase
        return f;
    endfunction

    function automatic logic [2:0] glyph_of(input logic [3:0] c);
        logic [2:0] g;
        case (c)
            4'd1, 4'd7, 4'd8, 4'd14:          g = GLYPH_SLASH;
            4'd2, 4'd4, 4'd11, 4'd13:         g = GLYPH_BACKSLASH;
            4'd3, 4'd12:                      g = GLYPH_DASH;
            4'd6, 4'd9:                       g = GLYPH_BAR;
            4'd5, 4'd10:                      g = GLYPH_CROSS;
            default:                          g = GLYPH_BLANK;
        endcase
        return g;
    endfunction

endpackage

/* src/marching_squares_cell_classifier_top.sv */
// A corner's result passes the stage-1 registers, the cell register, the queue and the output register before it shows.
// Throughput: one corner per cycle while full is low; the line buffer takes one read and one write per corner.
// Items at row 0 or column 0 of a frame give no result.
// Reset (i_rst_n low, synchronous): clears counters, edge corners, pipeline and queue,
// and loads threshold 819, single mode, 80 cells per row. The line buffer is not cleared.
module marching_squares_cell_classifier_top #(
    parameter int MAX_CORNERS_PER_ROW = 256,
    parameter int LEVEL_COUNT = 5,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [14:0] i_sample,
    input  logic        i_frame_start,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_cell_col,
    output logic [7:0]  o_cell_row,
    output logic [3:0]  o_case_index,
    output logic [2:0]  o_glyph,
    output logic [2:0]  o_style,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);

    localparam int CNW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW  = CNW + 2;

    mscc_pkg::t_cfg  r_cfg;
    mscc_pkg::t_cell w_push_cell, w_head;
    logic            w_accept, w_push, w_head_empty, w_head_pop;
    logic [1:0]      w_pending;
    logic [CNW-1:0]  w_count;
    logic [SW-1:0]   w_load;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold     <= 15'd819;
            r_cfg.multi_mode    <= 1'b0;
            r_cfg.cells_per_row <= 8'd80;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mscc_pkg::CFG_THRESHOLD:     r_cfg.threshold     <= i_cfg_data;
                mscc_pkg::CFG_MULTI_MODE:    r_cfg.multi_mode    <= i_cfg_data[0];
                mscc_pkg::CFG_CELLS_PER_ROW: r_cfg.cells_per_row <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign w_load   = SW'(w_count) + SW'(w_pending);
    assign full     = (w_load >= SW'(QUEUE_DEPTH));
    assign w_accept = push && !full;

    mscc_front #(
        .MAX_CORNERS_PER_ROW(MAX_CORNERS_PER_ROW),
        .LEVEL_COUNT(LEVEL_COUNT)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg(r_cfg),
        .i_accept(w_accept),
        .i_sample(i_sample),
        .i_frame_start(i_frame_start),
        .o_pending(w_pending),
        .o_push(w_push),
        .o_cell(w_push_cell)
    );

    mscc_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(w_push),
        .i_data(w_push_cell),
        .i_pop(w_head_pop),
        .o_data(w_head),
        .o_empty(w_head_empty),
        .o_count(w_count)
    );

    mscc_back #(
        .LEVEL_COUNT(LEVEL_COUNT)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_multi_mode(r_cfg.multi_mode),
        .i_cell(w_head),
        .i_cell_empty(w_head_empty),
        .o_cell_pop(w_head_pop),
        .i_pop(pop),
        .o_empty(empty),
        .o_cell_col(o_cell_col),
        .o_cell_row(o_cell_row),
        .o_case_index(o_case_index),
        .o_glyph(o_glyph),
        .o_style(o_style)
    );

endmodule

/* src/mscc_front.sv */
module mscc_front #(
    parameter int MAX_CORNERS_PER_ROW = 256,
    parameter int LEVEL_COUNT = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mscc_pkg::t_cfg       i_cfg,
    input  logic                 i_accept,
    input  logic [14:0]          i_sample,
    input  logic                 i_frame_start,
    output logic [1:0]           o_pending,
    output logic                 o_push,
    output mscc_pkg::t_cell      o_cell
);

    localparam int CW  = $clog2(MAX_CORNERS_PER_ROW);
    localparam int NW  = $clog2(MAX_CORNERS_PER_ROW + 1);
    localparam int KW  = (NW > 9) ? NW : 9;
    localparam logic [KW-1:0] MAXC = KW'(MAX_CORNERS_PER_ROW);

    logic [CW-1:0] r_col, n_col, w_col;
    logic [7:0]    r_row, n_row, w_row;
    logic [KW-1:0] w_cpr1, w_corners, w_col_inc;
    logic [7:0]    w_row_wrap, w_row_adv;

    logic [14:0] r_mem [MAX_CORNERS_PER_ROW];
    logic [14:0] r_above;

    logic        r_v1, r_res1;
    logic [14:0] r_s1;
    logic [7:0]  r_col1, r_row1;

    logic [14:0] r_ul, r_ll;
    logic [31:0] w_tl, w_tr, w_br, w_bl;
    logic [3:0]  w_base;
    logic [mscc_pkg::MAX_LEVELS-1:0][3:0] w_lvl;

    logic            r_v2;
    mscc_pkg::t_cell r_cell;

    assign w_cpr1     = KW'(i_cfg.cells_per_row) + KW'(1);
    assign w_corners  = (w_cpr1 > MAXC) ? MAXC : w_cpr1;
    assign w_row_wrap = (r_row == 8'd255) ? r_row : r_row + 8'd1;

    always_comb begin
        if (i_frame_start) begin
            w_col = '0;
            w_row = '0;
        end else if (KW'(r_col) >= w_corners) begin
            w_col = '0;
            w_row = w_row_wrap;
        end else begin
            w_col = r_col;
            w_row = r_row;
        end
    end

    assign w_col_inc = KW'(w_col) + KW'(1);
    assign w_row_adv = (w_row == 8'd255) ? w_row : w_row + 8'd1;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            if (w_col_inc >= w_corners) begin
                n_col = '0;
                n_row = w_row_adv;
            end else begin
                n_col = CW'(w_col_inc);
                n_row = w_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_above      <= r_mem[w_col];
            r_mem[w_col] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_res1 <= 1'b0;
        end else begin
            r_v1   <= i_accept;
            r_res1 <= i_accept && (w_row != 8'd0) && (w_col != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1   <= i_sample;
            r_col1 <= 8'(w_col) - 8'd1;
            r_row1 <= w_row - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ul <= '0;
            r_ll <= '0;
        end else if (r_v1) begin
            r_ul <= r_above;
            r_ll <= r_s1;
        end
    end

    assign w_tl = {1'b0, r_ul, 16'h0000};
    assign w_tr = {1'b0, r_above, 16'h0000};
    assign w_br = {1'b0, r_s1, 16'h0000};
    assign w_bl = {1'b0, r_ll, 16'h0000};

    assign w_base = {r_ul > i_cfg.threshold, r_above > i_cfg.threshold,
                     r_s1 > i_cfg.threshold, r_ll > i_cfg.threshold};

    for (genvar g = 0; g < mscc_pkg::MAX_LEVELS; g++) begin : g_level
        if (g < LEVEL_COUNT) begin : g_used
            logic [31:0] r_prod;
            always_ff @(posedge i_clk) begin
                r_prod <= 32'(i_cfg.threshold) * 32'(mscc_pkg::level_factor(3'(g)));
            end
            assign w_lvl[g] = {w_tl > r_prod, w_tr > r_prod, w_br > r_prod, w_bl > r_prod};
        end else begin : g_unused
            assign w_lvl[g] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_res1) begin
            r_cell.col       <= r_col1;
            r_cell.row       <= r_row1;
            r_cell.base_case <= w_base;
            r_cell.lvl_case  <= w_lvl;
        end
    end

    assign o_pending = {1'b0, r_res1} + {1'b0, r_v2};
    assign o_push    = r_v2;
    assign o_cell    = r_cell;

endmodule

/* src/mscc_fifo.sv */
module mscc_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  mscc_pkg::t_cell           i_data,
    input  logic                      i_pop,
    output mscc_pkg::t_cell           o_data,
    output logic                      o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH + 1);

    mscc_pkg::t_cell r_buf [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [CNW-1:0]  r_cnt, n_cnt;
    logic            w_pop;

    assign w_pop = i_pop && (r_cnt != '0);

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !w_pop) begin
            n_cnt = r_cnt + CNW'(1);
        end else if (!i_push && w_pop) begin
            n_cnt = r_cnt - CNW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + AW'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_data;
        end
    end

    assign o_data  = r_buf[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;

endmodule

/* src/mscc_back.sv */
module mscc_back #(
    parameter int LEVEL_COUNT = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_multi_mode,
    input  mscc_pkg::t_cell  i_cell,
    input  logic             i_cell_empty,
    output logic             o_cell_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [7:0]       o_cell_col,
    output logic [7:0]       o_cell_row,
    output logic [3:0]       o_case_index,
    output logic [2:0]       o_glyph,
    output logic [2:0]       o_style
);

    logic       r_ov;
    logic       w_take, w_hit;
    logic [3:0] w_idx;
    logic [2:0] w_glyph, w_style;

    always_comb begin
        w_idx   = i_cell.base_case;
        w_glyph = mscc_pkg::GLYPH_BLANK;
        w_style = mscc_pkg::STYLE_NONE;
        w_hit   = 1'b0;
        if (!i_multi_mode) begin
            if (i_cell.base_case == mscc_pkg::CASE_FULL) begin
                w_glyph = mscc_pkg::GLYPH_DOT_FILL;
                w_style = mscc_pkg::STYLE_INSIDE;
            end else if (i_cell.base_case != mscc_pkg::CASE_EMPTY) begin
                w_glyph = mscc_pkg::glyph_of(i_cell.base_case);
                w_style = mscc_pkg::STYLE_CONTOUR;
            end
        end else begin
            for (int lv = 0; lv < LEVEL_COUNT; lv++) begin
                if (!w_hit && i_cell.lvl_case[lv] != mscc_pkg::CASE_EMPTY
                        && i_cell.lvl_case[lv] != mscc_pkg::CASE_FULL) begin
                    w_hit   = 1'b1;
                    w_idx   = i_cell.lvl_case[lv];
                    w_glyph = mscc_pkg::glyph_of(i_cell.lvl_case[lv]);
                    w_style = (lv >= 4) ? mscc_pkg::STYLE_LEVEL_TOP
                                        : mscc_pkg::STYLE_LEVEL0 + 3'(lv);
                end
            end
            if (!w_hit && i_cell.base_case[3]) begin
                w_glyph = mscc_pkg::GLYPH_FAINT;
                w_style = mscc_pkg::STYLE_INSIDE;
            end
        end
    end

    assign w_take     = !i_cell_empty && (!r_ov || i_pop);
    assign o_cell_pop = w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_take) begin
            r_ov <= 1'b1;
        end else if (i_pop) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            o_cell_col   <= i_cell.col;
            o_cell_row   <= i_cell.row;
            o_case_index <= w_idx;
            o_glyph      <= w_glyph;
            o_style      <= w_style;
        end
    end

    assign o_empty = !r_ov;

endmodule

/* src/mscc_checker.sv */
module mscc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_cell_col,
    input logic [7:0] o_cell_row,
    input logic [3:0] o_case_index,
    input logic [2:0] o_glyph,
    input logic [2:0] o_style
);

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queue not clear after reset");

    a_coord_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_cell_col != 8'd255 && o_cell_row != 8'd255)
        else $error("cell coordinate out of range");

    a_glyph_style: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |->
            (o_style == mscc_pkg::STYLE_NONE && o_glyph == mscc_pkg::GLYPH_BLANK) ||
            (o_style == mscc_pkg::STYLE_INSIDE &&
                (o_glyph == mscc_pkg::GLYPH_DOT_FILL || o_glyph == mscc_pkg::GLYPH_FAINT)) ||
            (o_style != mscc_pkg::STYLE_NONE && o_style != mscc_pkg::STYLE_INSIDE &&
                o_glyph != mscc_pkg::GLYPH_BLANK && o_glyph != mscc_pkg::GLYPH_DOT_FILL &&
                o_glyph != mscc_pkg::GLYPH_FAINT &&
                o_case_index != mscc_pkg::CASE_EMPTY && o_case_index != mscc_pkg::CASE_FULL))
        else $error("glyph does not match style");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_glyph) && $stable(o_cell_col)
            && $stable(o_cell_row))
        else $error("waiting transaction changed");

endmodule

bind marching_squares_cell_classifier_top mscc_checker u_mscc_checker (.*);

/* test/tb_marching_squares_cell_classifier_top.sv */
`timescale 1ns / 1ps

module tb_marching_squares_cell_classifier_top;

    localparam int MAX_CORNERS = 256;
    localparam int LEVELS      = 5;
    localparam int DRAIN_WAIT  = 8;
    localparam int CYCLE_LIMIT = 300000;

    localparam logic [16:0] LEVEL_SCALE [LEVELS] = '{
        17'd19661, 17'd29491, 17'd39322, 17'd49152, 17'd58982
    };

    localparam logic [2:0] GLYPH_BY_CASE [16] = '{
        mscc_pkg::GLYPH_BLANK, mscc_pkg::GLYPH_SLASH,
        mscc_pkg::GLYPH_BACKSLASH, mscc_pkg::GLYPH_DASH,
        mscc_pkg::GLYPH_BACKSLASH, mscc_pkg::GLYPH_CROSS,
        mscc_pkg::GLYPH_BAR, mscc_pkg::GLYPH_SLASH,
        mscc_pkg::GLYPH_SLASH, mscc_pkg::GLYPH_BAR,
        mscc_pkg::GLYPH_CROSS, mscc_pkg::GLYPH_BACKSLASH,
        mscc_pkg::GLYPH_DASH, mscc_pkg::GLYPH_BACKSLASH,
        mscc_pkg::GLYPH_SLASH, mscc_pkg::GLYPH_BLANK
    };

    localparam logic [14:0] SINGLE_FRAME [9] = '{
        15'd32767, 15'd0,     15'd32767,
        15'd0,     15'd32767, 15'd819,
        15'd820,   15'd820,   15'd0
    };

    localparam logic [14:0] LEVEL_FRAME [14] = '{
        15'd32767, 15'd32767,
        15'd32767, 15'd32767,
        15'd7000,  15'd5000,
        15'd0,     15'd0,
        15'd0,     15'd0,
        15'd16000, 15'd19000,
        15'd19000, 15'd19000
    };

    typedef struct {
        logic [14:0] sample;
        logic        frame_start;
    } t_corner;

    typedef struct {
        logic [7:0] col;
        logic [7:0] row;
        logic [3:0] case_idx;
        logic [2:0] glyph;
        logic [2:0] style;
    } t_cell_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [14:0] i_sample = '0;
    logic        i_frame_start = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_cell_col;
    logic [7:0]  o_cell_row;
    logic [3:0]  o_case_index;
    logic [2:0]  o_glyph;
    logic [2:0]  o_style;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = mscc_pkg::CFG_THRESHOLD;
    logic [14:0] i_cfg_data = '0;

    t_corner      pending_corners [$];
    t_cell_result expected_cells [$];

    logic [14:0] cfg_threshold;
    logic        cfg_multi;
    logic [7:0]  cfg_cells;
    logic [14:0] line_buf [MAX_CORNERS];
    logic [14:0] left_upper;
    logic [14:0] left_lower;
    int          corner_col;
    int          corner_row;

    int queued_count = 0;
    int accepted_count = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int stall_timer = 0;

    marching_squares_cell_classifier_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_sample      (i_sample),
        .i_frame_start (i_frame_start),
        .empty         (empty),
        .pop           (pop),
        .o_cell_col    (o_cell_col),
        .o_cell_row    (o_cell_row),
        .o_case_index  (o_case_index),
        .o_glyph       (o_glyph),
        .o_style       (o_style),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void reset_classifier();
        cfg_threshold = 15'd819;
        cfg_multi     = 1'b0;
        cfg_cells     = 8'd80;
        foreach (line_buf[i]) line_buf[i] = '0;
        left_upper = '0;
        left_lower = '0;
        corner_col = 0;
        corner_row = 0;
    endfunction

    function automatic logic [3:0] corner_bits(input logic [14:0] tl, input logic [14:0] tr,
                                               input logic [14:0] br, input logic [14:0] bl,
                                               input logic [47:0] level);
        corner_bits = {48'({tl, 16'd0}) > level, 48'({tr, 16'd0}) > level,
                       48'({br, 16'd0}) > level, 48'({bl, 16'd0}) > level};
    endfunction

    function automatic void classify_corner(input logic [14:0] s, input logic fs);
        int           corners;
        int           col;
        int           row;
        logic [14:0]  above;
        logic [3:0]   lvl_bits;
        logic         crossed;
        t_cell_result res;
        corners = int'(cfg_cells) + 1;
        if (corners > MAX_CORNERS) corners = MAX_CORNERS;
        if (fs) begin
            corner_col = 0;
            corner_row = 0;
        end else if (corner_col >= corners) begin
            corner_col = 0;
            if (corner_row < 255) corner_row++;
        end
        col = corner_col;
        row = corner_row;
        above = line_buf[col];
        if (row >= 1 && col >= 1) begin
            res.col = 8'(col - 1);
            res.row = 8'(row - 1);
            res.case_idx = corner_bits(left_upper, above, s, left_lower,
                                       48'({cfg_threshold, 16'd0}));
            res.glyph = mscc_pkg::GLYPH_BLANK;
            res.style = mscc_pkg::STYLE_NONE;
            if (!cfg_multi) begin
                if (res.case_idx == mscc_pkg::CASE_FULL) begin
                    res.glyph = mscc_pkg::GLYPH_DOT_FILL;
                    res.style = mscc_pkg::STYLE_INSIDE;
                end else if (res.case_idx != mscc_pkg::CASE_EMPTY) begin
                    res.glyph = GLYPH_BY_CASE[res.case_idx];
                    res.style = mscc_pkg::STYLE_CONTOUR;
                end
            end else begin
                crossed = 1'b0;
                for (int lv = 0; lv < LEVELS; lv++) begin
                    if (!crossed) begin
                        lvl_bits = corner_bits(left_upper, above, s, left_lower,
                                               48'(cfg_threshold) * 48'(LEVEL_SCALE[lv]));
                        if (lvl_bits != mscc_pkg::CASE_EMPTY &&
                                lvl_bits != mscc_pkg::CASE_FULL) begin
                            crossed = 1'b1;
                            res.case_idx = lvl_bits;
                            res.glyph = GLYPH_BY_CASE[lvl_bits];
                            res.style = (lv + 3 > 7) ? mscc_pkg::STYLE_LEVEL_TOP
                                                     : mscc_pkg::STYLE_LEVEL0 + 3'(lv);
                        end
                    end
                end
                if (!crossed && left_upper > cfg_threshold) begin
                    res.glyph = mscc_pkg::GLYPH_FAINT;
                    res.style = mscc_pkg::STYLE_INSIDE;
                end
            end
            expected_cells.push_back(res);
        end
        left_upper = above;
        left_lower = s;
        line_buf[col] = s;
        if (col + 1 >= corners) begin
            corner_col = 0;
            if (corner_row < 255) corner_row++;
        end else begin
            corner_col = col + 1;
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic logic [14:0] pick_sample(input logic [14:0] thr);
        int roll;
        int val;
        int lv;
        roll = $urandom_range(0, 99);
        if (roll < 20) begin
            val = $urandom_range(0, 32767);
        end else if (roll < 30) begin
            case ($urandom_range(0, 3))
                0:       val = 0;
                1:       val = 32767;
                2:       val = thr;
                default: val = int'(thr) + 1;
            endcase
        end else if (roll < 60) begin
            lv = $urandom_range(0, LEVELS - 1);
            val = int'((48'(thr) * 48'(LEVEL_SCALE[lv])) >> 16) + $urandom_range(0, 1);
        end else begin
            val = (int'(thr) * $urandom_range(20, 110)) / 100;
        end
        if (val > 32767) val = 32767;
        return 15'(val);
    endfunction

    always @(posedge i_clk) begin : corner_driver
        t_corner next_corner;
        if (!i_rst_n) begin
            push <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (push && !full) begin
                classify_corner(i_sample, i_frame_start);
                accepted_count++;
            end
            if (!(push && full)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    push <= 1'b0;
                end else if (pending_corners.size() != 0) begin
                    next_corner = pending_corners.pop_front();
                    i_sample <= next_corner.sample;
                    i_frame_start <= next_corner.frame_start;
                    push <= 1'b1;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        if ($urandom_range(0, 3) == 0) begin
                            burst_left = $urandom_range(40, 150);
                            gap_left = 0;
                        end else begin
                            burst_left = $urandom_range(1, 8);
                            gap_left = $urandom_range(1, 6);
                        end
                    end
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : cell_monitor
        t_cell_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
            stall_mode = 0;
            stall_timer = 0;
        end else begin
            if (pop && !empty) begin
                if (expected_cells.size() == 0) begin
                    $error("cell transaction with none expected: col %0d row %0d",
                           o_cell_col, o_cell_row);
                    fail_count++;
                end else begin
                    want = expected_cells.pop_front();
                    check_field("cell_col", want.col, o_cell_col);
                    check_field("cell_row", want.row, o_cell_row);
                    check_field("case_index", want.case_idx, o_case_index);
                    check_field("glyph", want.glyph, o_glyph);
                    check_field("style", want.style, o_style);
                end
            end
            if (stall_timer == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_timer = $urandom_range(16, 96);
            end else begin
                stall_timer--;
            end
            case (stall_mode)
                0:       pop <= 1'b1;
                1:       pop <= 1'($urandom_range(0, 1));
                default: pop <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic add_corner(input logic [14:0] sample, input logic fs);
        t_corner c;
        c.sample = sample;
        c.frame_start = fs;
        pending_corners.push_back(c);
        queued_count++;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (accepted_count != queued_count || expected_cells.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [14:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (index)
            mscc_pkg::CFG_THRESHOLD:     cfg_threshold = value;
            mscc_pkg::CFG_MULTI_MODE:    cfg_multi = value[0];
            mscc_pkg::CFG_CELLS_PER_ROW: cfg_cells = value[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [14:0] thr, input logic mode, input logic [7:0] cells);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(mscc_pkg::CFG_THRESHOLD, thr);
        write_reg(mscc_pkg::CFG_MULTI_MODE, {junk[13:0], mode});
        write_reg(mscc_pkg::CFG_CELLS_PER_ROW, {junk[20:14], cells});
    endtask

    task automatic feed_random(input int count, input bit restart, input int restart_odds);
        logic fs;
        for (int n = 0; n < count; n++) begin
            fs = (n == 0 && restart) ||
                 (restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
            add_corner(pick_sample(cfg_threshold), fs);
        end
        wait_idle();
    endtask

    initial begin
        logic [14:0] thr;
        reset_classifier();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_config(15'd819, 1'b0, 8'd2);
        foreach (SINGLE_FRAME[i]) add_corner(SINGLE_FRAME[i], i == 0);
        wait_idle();

        set_config(15'd20000, 1'b1, 8'd1);
        foreach (LEVEL_FRAME[i]) add_corner(LEVEL_FRAME[i], i == 0);
        wait_idle();

        set_config(15'd32767, 1'b0, 8'd0);
        add_corner(15'd32767, 1'b1);
        add_corner(15'd0, 1'b0);
        add_corner(15'd12345, 1'b0);
        wait_idle();

        set_config(15'($urandom_range(1, 32766)), 1'b0, 8'd255);
        feed_random(300, 1'b1, 0);

        // row counter runs into saturation with two corners per row
        set_config(15'd32767, 1'b1, 8'd1);
        feed_random(540, 1'b1, 0);

        set_config(15'd0, 1'b0, 8'd20);
        feed_random(130, 1'b1, 60);
        // shrink the row mid-frame and carry on without a restart
        write_reg(mscc_pkg::CFG_CELLS_PER_ROW, 15'd7);
        feed_random(80, 1'b0, 0);

        repeat (4) begin
            if ($urandom_range(0, 3) == 0)
                thr = ($urandom_range(0, 1) != 0) ? 15'd32767 : 15'd0;
            else
                thr = 15'($urandom_range(1, 32766));
            set_config(thr, 1'($urandom_range(0, 1)), 8'($urandom_range(2, 40)));
            feed_random(80, 1'b1, 50);
        end

        wait_idle();
        if (fail_count == 0 && expected_cells.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
